/* rtl/core/complex_arithmetic_unit_core_macros.svh */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_macros.svh
// Assertion macros used by the core top file.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Implication checked outside reset.
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Opcodes, result kinds and the control word carried along the cell chain.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int OPCODE_W = 4;

  localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_CONJ  = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_NEG   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_TIMESI = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_MAG   = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_RECIP = 4'd8;

  typedef enum logic [2:0] {
    KIND_DIRECT = 3'b001,
    KIND_DIV    = 3'b010,
    KIND_SQRT   = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  dz;
    logic  sat;
    logic  neg_re;
    logic  neg_im;
    logic  ovf_re;
    logic  ovf_im;
  } ctl_t;

endpackage

/* rtl/core/cau_in_if.sv */
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: opcode and two complex operands.
// ----------------------------------------------------------------------------
interface cau_in_if
  import cau_pkg::*;
#(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic signed [W-1:0] a_real;
  logic signed [W-1:0] a_imag;
  logic signed [W-1:0] b_real;
  logic signed [W-1:0] b_imag;

  modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

/* rtl/core/cau_out_if.sv */
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status flags.
// ----------------------------------------------------------------------------
interface cau_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_real;
  logic signed [W-1:0] res_imag;
  logic                divide_by_zero;
  logic                saturated;

  modport source (output valid, res_real, res_imag, divide_by_zero, saturated, input ready);
  modport sink   (input valid, res_real, res_imag, divide_by_zero, saturated, output ready);
endinterface

/* rtl/core/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front
// Operand register, product stage and chain setup stage.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic signed [W-1:0] in_ar,
  input  logic signed [W-1:0] in_ai,
  input  logic signed [W-1:0] in_br,
  input  logic signed [W-1:0] in_bi,
  output logic                valid,
  output ctl_t                ctl,
  output logic [W-1:0]        dir_re,
  output logic [W-1:0]        dir_im,
  output logic [2*W-1:0]      den,
  output logic [2*W:0]        rem [2],
  output logic [2*W-1:0]      nb [2]
);

  localparam int XW = 2 * W + 1;
  localparam int NW = 2 * W + F;
  localparam int CW = 3 * W;
  localparam int RW = 2 * W + 1;
  localparam logic [XW-1:0] POS_LIM = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] NEG_LIM = POS_LIM + XW'(1);

  function automatic logic [W:0] clip(input logic neg, input logic [XW-1:0] mag);
    logic [XW-1:0] n;
    n = XW'(0) - mag;
    if (!neg && mag > POS_LIM)      clip = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (neg && mag > NEG_LIM)  clip = {1'b1, 1'b1, {(W-1){1'b0}}};
    else if (neg)                   clip = {1'b0, n[W-1:0]};
    else                            clip = {1'b0, mag[W-1:0]};
  endfunction

  // operand register
  logic                a_vld;
  logic [OPCODE_W-1:0] a_op;
  logic signed [W-1:0] a_ar, a_ai, a_br, a_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= in_valid;
    end
    if (advance) begin
      a_op <= in_opcode;
      a_ar <= in_ar;
      a_ai <= in_ai;
      a_br <= in_br;
      a_bi <= in_bi;
    end
  end

  // product stage
  logic signed [W-1:0]   d_r, d_i;
  logic                  b_vld;
  logic [OPCODE_W-1:0]   b_op;
  logic signed [W-1:0]   b_ar, b_ai, b_br, b_bi;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, s_r, s_i;

  assign d_r = (a_op == OP_DIV) ? a_br : a_ar;
  assign d_i = (a_op == OP_DIV) ? a_bi : a_ai;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (advance) begin
      b_vld <= a_vld;
    end
    if (advance) begin
      b_op <= a_op;
      b_ar <= a_ar;
      b_ai <= a_ai;
      b_br <= a_br;
      b_bi <= a_bi;
      p_rr <= a_ar * a_br;
      p_ii <= a_ai * a_bi;
      p_ri <= a_ar * a_bi;
      p_ir <= a_ai * a_br;
      s_r  <= d_r * d_r;
      s_i  <= d_i * d_i;
    end
  end

  // setup stage
  logic [2*W-1:0]       den_c;
  logic signed [XW-1:0] n_re, n_im, v_re, v_im;
  logic                 ng_re, ng_im, vn_re, vn_im, is_div, is_mul, dz_c;
  logic [XW-1:0]        m_re, m_im, vm_re, vm_im;
  logic [NW-1:0]        nm_re, nm_im;
  logic [CW-1:0]        den_sh;
  logic [W:0]           c_re, c_im;
  ctl_t                 ctl_c;

  always_comb begin
    den_c  = $unsigned(s_r) + $unsigned(s_i);
    is_div = (b_op == OP_DIV) || (b_op == OP_RECIP);
    is_mul = (b_op == OP_MUL);
    dz_c   = is_div && (den_c == '0);
    if (b_op == OP_DIV) begin
      n_re = XW'(p_rr) + XW'(p_ii);
      n_im = XW'(p_ir) - XW'(p_ri);
    end else begin
      n_re = XW'(b_ar);
      n_im = XW'(0) - XW'(b_ai);
    end
    ng_re = n_re[XW-1];
    ng_im = n_im[XW-1];
    m_re  = ng_re ? XW'(0) - n_re : n_re;
    m_im  = ng_im ? XW'(0) - n_im : n_im;
    if (b_op == OP_DIV) begin
      nm_re = NW'(m_re) << F;
      nm_im = NW'(m_im) << F;
    end else begin
      nm_re = NW'(m_re) << (2 * F);
      nm_im = NW'(m_im) << (2 * F);
    end
    den_sh = {den_c, {W{1'b0}}};

    case (b_op)
      OP_ADD: begin
        v_re = XW'(b_ar) + XW'(b_br);
        v_im = XW'(b_ai) + XW'(b_bi);
      end
      OP_SUB: begin
        v_re = XW'(b_ar) - XW'(b_br);
        v_im = XW'(b_ai) - XW'(b_bi);
      end
      OP_MUL: begin
        v_re = XW'(p_rr) - XW'(p_ii);
        v_im = XW'(p_ri) + XW'(p_ir);
      end
      OP_CONJ: begin
        v_re = XW'(b_ar);
        v_im = XW'(0) - XW'(b_ai);
      end
      OP_NEG: begin
        v_re = XW'(0) - XW'(b_ar);
        v_im = XW'(0) - XW'(b_ai);
      end
      OP_TIMESI: begin
        v_re = XW'(0) - XW'(b_ai);
        v_im = XW'(b_ar);
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    vn_re = v_re[XW-1];
    vn_im = v_im[XW-1];
    vm_re = vn_re ? XW'(0) - v_re : v_re;
    vm_im = vn_im ? XW'(0) - v_im : v_im;
    if (is_mul) begin
      vm_re = vm_re >> F;
      vm_im = vm_im >> F;
    end
    c_re = clip(vn_re, vm_re);
    c_im = clip(vn_im, vm_im);

    ctl_c.dz     = dz_c;
    ctl_c.sat    = c_re[W] | c_im[W];
    ctl_c.neg_re = ng_re;
    ctl_c.neg_im = ng_im;
    ctl_c.ovf_re = CW'(nm_re) >= den_sh;
    ctl_c.ovf_im = CW'(nm_im) >= den_sh;
    if (b_op == OP_MAG)       ctl_c.kind = KIND_SQRT;
    else if (is_div && !dz_c) ctl_c.kind = KIND_DIV;
    else                      ctl_c.kind = KIND_DIRECT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= b_vld;
    end
    if (advance) begin
      ctl    <= ctl_c;
      dir_re <= c_re[W-1:0];
      dir_im <= c_im[W-1:0];
      den    <= den_c;
      if (ctl_c.kind == KIND_SQRT) begin
        rem[0] <= '0;
        nb[0]  <= den_c;
      end else begin
        rem[0] <= RW'(nm_re >> W);
        nb[0]  <= {nm_re[W-1:0], {W{1'b0}}};
      end
      rem[1] <= RW'(nm_im >> W);
      nb[1]  <= {nm_im[W-1:0], {W{1'b0}}};
    end
  end

endmodule

/* rtl/core/cau_cell.sv */
// ----------------------------------------------------------------------------
// cau_cell
// One chain cell: a restoring divide step or a square-root digit step per lane.
// ----------------------------------------------------------------------------
module cau_cell
  import cau_pkg::*;
#(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           valid_i,
  input  ctl_t           ctl_i,
  input  logic [W-1:0]   dir_re_i,
  input  logic [W-1:0]   dir_im_i,
  input  logic [2*W-1:0] den_i,
  input  logic [2*W:0]   rem_i [2],
  input  logic [2*W-1:0] nb_i [2],
  input  logic [W-1:0]   q_i [2],
  output logic           valid_o,
  output ctl_t           ctl_o,
  output logic [W-1:0]   dir_re_o,
  output logic [W-1:0]   dir_im_o,
  output logic [2*W-1:0] den_o,
  output logic [2*W:0]   rem_o [2],
  output logic [2*W-1:0] nb_o [2],
  output logic [W-1:0]   q_o [2]
);

  localparam int RW = 2 * W + 1;

  logic sq;
  assign sq = (ctl_i.kind == KIND_SQRT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (advance) begin
      valid_o <= valid_i;
    end
    if (advance) begin
      ctl_o    <= ctl_i;
      dir_re_o <= dir_re_i;
      dir_im_o <= dir_im_i;
      den_o    <= den_i;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [RW-1:0] rsh, trial, rdiff;
    logic          ge;

    always_comb begin
      if (sq) begin
        rsh   = {rem_i[l][RW-3:0], nb_i[l][2*W-1 -: 2]};
        trial = {{(RW-W-2){1'b0}}, q_i[l], 2'b01};
      end else begin
        rsh   = {rem_i[l][RW-2:0], nb_i[l][2*W-1]};
        trial = {1'b0, den_i};
      end
      ge    = rsh >= trial;
      rdiff = rsh - trial;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_o[l] <= ge ? rdiff : rsh;
        q_o[l]   <= {q_i[l][W-2:0], ge};
        nb_o[l]  <= sq ? nb_i[l] << 2 : nb_i[l] << 1;
      end
    end
  end

endmodule

/* rtl/core/complex_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Path: operand register, product and setup stages, the cell chain, output register.
// Throughput: one word per cycle while the sink is not stalling; the DATA_WIDTH-cell
// divide/root chain is fully pipelined, one quotient or root bit per cell.
// The whole pipe holds while a result word waits on a stalled sink.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_core_macros.svh"

module complex_arithmetic_unit_core
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  cau_in_if.sink    operands,
  cau_out_if.source result
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = 2 * W + 1;
  localparam logic [XW-1:0] POS_LIM = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] NEG_LIM = POS_LIM + XW'(1);

  // Clip a sign/magnitude value to the W-bit range; top bit flags a clip.
  function automatic logic [W:0] clip(input logic neg, input logic [XW-1:0] mag);
    logic [XW-1:0] n;
    n = XW'(0) - mag;
    if (!neg && mag > POS_LIM)      clip = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (neg && mag > NEG_LIM)  clip = {1'b1, 1'b1, {(W-1){1'b0}}};
    else if (neg)                   clip = {1'b0, n[W-1:0]};
    else                            clip = {1'b0, mag[W-1:0]};
  endfunction

  // Advance the whole pipe whenever the output register is free or drains.
  logic advance;
  assign advance        = !result.valid || result.ready;
  assign operands.ready = advance;

  // Chain taps: index 0 is the setup stage, index W the last cell.
  logic           vld    [W+1];
  ctl_t           ctl    [W+1];
  logic [W-1:0]   dir_re [W+1];
  logic [W-1:0]   dir_im [W+1];
  logic [2*W-1:0] den    [W+1];
  logic [2*W:0]   rem    [W+1][2];
  logic [2*W-1:0] nb     [W+1][2];
  logic [W-1:0]   q      [W+1][2];

  cau_front #(
    .W (W),
    .F (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (operands.valid),
    .in_opcode (operands.opcode),
    .in_ar     (operands.a_real),
    .in_ai     (operands.a_imag),
    .in_br     (operands.b_real),
    .in_bi     (operands.b_imag),
    .valid     (vld[0]),
    .ctl       (ctl[0]),
    .dir_re    (dir_re[0]),
    .dir_im    (dir_im[0]),
    .den       (den[0]),
    .rem       (rem[0]),
    .nb        (nb[0])
  );

  // Quotient/root registers start empty; each cell shifts in one bit.
  assign q[0][0] = '0;
  assign q[0][1] = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    cau_cell #(
      .W (W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .valid_i  (vld[k]),
      .ctl_i    (ctl[k]),
      .dir_re_i (dir_re[k]),
      .dir_im_i (dir_im[k]),
      .den_i    (den[k]),
      .rem_i    (rem[k]),
      .nb_i     (nb[k]),
      .q_i      (q[k]),
      .valid_o  (vld[k+1]),
      .ctl_o    (ctl[k+1]),
      .dir_re_o (dir_re[k+1]),
      .dir_im_o (dir_im[k+1]),
      .den_o    (den[k+1]),
      .rem_o    (rem[k+1]),
      .nb_o     (nb[k+1]),
      .q_o      (q[k+1])
    );
  end

  // Final stage: apply sign and clip to quotients, clip the root, else pass through.
  ctl_t          fc;
  logic [XW-1:0] fq_re, fq_im;
  logic [W:0]    f_re, f_im;
  logic          f_sat;

  always_comb begin
    fc    = ctl[W];
    fq_re = fc.ovf_re ? {XW{1'b1}} : XW'(q[W][0]);
    fq_im = fc.ovf_im ? {XW{1'b1}} : XW'(q[W][1]);
    case (fc.kind)
      KIND_DIV: begin
        f_re = clip(fc.neg_re, fq_re);
        f_im = clip(fc.neg_im, fq_im);
      end
      KIND_SQRT: begin
        f_re = clip(1'b0, XW'(q[W][0]));
        f_im = '0;
      end
      default: begin
        f_re = {1'b0, dir_re[W]};
        f_im = {1'b0, dir_im[W]};
      end
    endcase
    f_sat = fc.sat | f_re[W] | f_im[W];
  end

  // Output register: hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= vld[W];
    end
    if (advance) begin
      result.res_real       <= f_re[W-1:0];
      result.res_imag       <= f_im[W-1:0];
      result.divide_by_zero <= fc.dz;
      result.saturated      <= f_sat;
    end
  end

  // A zero divisor gives a clean zero result with no clip.
  `CAU_ASSERT_IMPL(a_dz_zero, result.valid && result.divide_by_zero, result.res_real == '0 && result.res_imag == '0 && !result.saturated)
  // A clipped result carries a range limit in at least one part.
  `CAU_ASSERT_IMPL(a_sat_limit, result.valid && result.saturated, result.res_real == POS_LIM[W-1:0] || result.res_real == NEG_LIM[W-1:0] || result.res_imag == POS_LIM[W-1:0] || result.res_imag == NEG_LIM[W-1:0])
  // Drop everything in flight on reset.
  `CAU_ASSERT_NEXT(a_rst_empty, rst, !result.valid && !vld[0])

endmodule
